// ===== rtl/sts_pkg.sv =====
// shared types and codes for the script token scanner
`default_nettype none

package sts_pkg;

    // scanner mode codes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_IDENT   = 3'd4;
    localparam logic [2:0] MODE_EQ      = 3'd5;

    // token kind codes
    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_STRING = 5'd2;
    localparam logic [4:0] KIND_NUMBER = 5'd3;
    localparam logic [4:0] KIND_LBRACE = 5'd4;
    localparam logic [4:0] KIND_RBRACE = 5'd5;
    localparam logic [4:0] KIND_LPAREN = 5'd6;
    localparam logic [4:0] KIND_RPAREN = 5'd7;
    localparam logic [4:0] KIND_SEMI   = 5'd8;
    localparam logic [4:0] KIND_COMMA  = 5'd9;
    localparam logic [4:0] KIND_PLUS   = 5'd10;
    localparam logic [4:0] KIND_MINUS  = 5'd11;
    localparam logic [4:0] KIND_STAR   = 5'd12;
    localparam logic [4:0] KIND_SLASH  = 5'd13;
    localparam logic [4:0] KIND_PCT    = 5'd14;
    localparam logic [4:0] KIND_EQ     = 5'd15;
    localparam logic [4:0] KIND_EQEQ   = 5'd16;
    localparam logic [4:0] KIND_LT     = 5'd17;
    localparam logic [4:0] KIND_GT     = 5'd18;
    localparam logic [4:0] KIND_ERROR  = 5'd19;

    // character codes the scanner treats specially
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // one token record
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
    } t_token;

    // tokens produced by one source byte, in emit order
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_lex_tokens;

endpackage

`default_nettype wire

// ===== rtl/sts_lexer.sv =====
// per-byte scan logic: token decisions and next scanner state
`default_nettype none

module sts_lexer
    import sts_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic [7:0]               i_byte,
    input  wire logic [2:0]               i_mode,
    input  wire logic [POSITION_BITS-1:0] i_pos,
    input  wire logic [POSITION_BITS-1:0] i_pstart,
    output t_lex_tokens                   o_tokens,
    output logic [2:0]                    o_mode,
    output logic [POSITION_BITS-1:0]      o_pos,
    output logic [POSITION_BITS-1:0]      o_pstart
);

    localparam int P = POSITION_BITS;
    localparam int W = (P > 16) ? P : 16;

    // clamp a position value to the 16-bit token fields
    function automatic logic [15:0] sat16(input logic [P-1:0] v);
        logic [W-1:0] wide;
        wide = W'(v);
        if (wide > W'(17'h0FFFF)) begin
            return 16'hFFFF;
        end
        return wide[15:0];
    endfunction

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        if (v == {P{1'b1}}) begin
            return v;
        end
        return v + P'(1);
    endfunction

    // single-character punctuation, zero when none
    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        unique case (b)
            8'h7B:   return KIND_LBRACE;
            8'h7D:   return KIND_RBRACE;
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            8'h3B:   return KIND_SEMI;
            8'h2C:   return KIND_COMMA;
            8'h2B:   return KIND_PLUS;
            8'h2D:   return KIND_MINUS;
            8'h2A:   return KIND_STAR;
            8'h2F:   return KIND_SLASH;
            8'h25:   return KIND_PCT;
            8'h3C:   return KIND_LT;
            8'h3E:   return KIND_GT;
            default: return KIND_EOF;
        endcase
    endfunction

    logic           is_end;
    logic           is_decimal;
    logic           is_letter;
    logic           is_space;
    logic [4:0]     pk;
    logic           consumed;
    logic           have_a;
    logic           have_b;
    t_token         tok_a;
    t_token         tok_b;
    logic [15:0]    plen;
    logic [P-1:0]   pdiff;

    always_comb begin
        is_end     = (i_byte == CH_NUL);
        is_decimal = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_letter  = ((i_byte >= 8'h61) && (i_byte <= 8'h7A)) ||
                     ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) || (i_byte == CH_UNDER);
        case (i_byte)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: is_space = 1'b1;
            default:                        is_space = 1'b0;
        endcase
        pk    = punct_kind(i_byte);
        pdiff = (i_pos >= i_pstart) ? (i_pos - i_pstart) : '0;
        plen  = sat16(pdiff);
    end

    // close the pending token, then scan the byte itself
    always_comb begin
        consumed = 1'b0;
        have_a   = 1'b0;
        have_b   = 1'b0;
        tok_a    = '{kind: KIND_EOF, offset: sat16(i_pstart), length: plen};
        tok_b    = '{kind: KIND_EOF, offset: sat16(i_pos), length: 16'd1};
        o_mode   = i_mode;
        o_pstart = i_pstart;
        o_pos    = sat_inc(i_pos);

        unique case (i_mode)
            MODE_COMMENT: begin
                if (i_byte == CH_LF) begin
                    o_mode = MODE_IDLE;
                end
                consumed = !is_end;
            end
            MODE_STRING: begin
                if (is_end || (i_byte == CH_QUOTE)) begin
                    have_a     = 1'b1;
                    tok_a.kind = KIND_STRING;
                end
                if (i_byte == CH_QUOTE) begin
                    o_mode = MODE_IDLE;
                end
                consumed = !is_end;
            end
            MODE_NUMBER: begin
                if (is_decimal) begin
                    consumed = 1'b1;
                end else begin
                    have_a     = 1'b1;
                    tok_a.kind = KIND_NUMBER;
                    o_mode     = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                if (is_letter || is_decimal) begin
                    consumed = 1'b1;
                end else begin
                    have_a     = 1'b1;
                    tok_a.kind = KIND_IDENT;
                    o_mode     = MODE_IDLE;
                end
            end
            MODE_EQ: begin
                o_mode = MODE_IDLE;
                have_a = 1'b1;
                if (i_byte == CH_EQ) begin
                    tok_a.kind   = KIND_EQEQ;
                    tok_a.length = 16'd2;
                    consumed     = 1'b1;
                end else begin
                    tok_a.kind   = KIND_EQ;
                    tok_a.length = 16'd1;
                end
            end
            default: begin
                o_mode = MODE_IDLE;
            end
        endcase

        if (is_end) begin
            // end of script: eof at current offset, back to reset state
            have_b       = 1'b1;
            tok_b.kind   = KIND_EOF;
            tok_b.length = 16'd0;
            o_mode       = MODE_IDLE;
            o_pos        = '0;
            o_pstart     = '0;
        end else if (!consumed) begin
            if (is_space) begin
                have_b = 1'b0;
            end else if (i_byte == CH_HASH) begin
                o_mode = MODE_COMMENT;
            end else if (pk != KIND_EOF) begin
                have_b     = 1'b1;
                tok_b.kind = pk;
            end else if (i_byte == CH_EQ) begin
                o_mode   = MODE_EQ;
                o_pstart = i_pos;
            end else if (i_byte == CH_QUOTE) begin
                o_mode   = MODE_STRING;
                o_pstart = sat_inc(i_pos);
            end else if (is_decimal) begin
                o_mode   = MODE_NUMBER;
                o_pstart = i_pos;
            end else if (is_letter) begin
                o_mode   = MODE_IDENT;
                o_pstart = i_pos;
            end else begin
                have_b     = 1'b1;
                tok_b.kind = KIND_ERROR;
            end
        end
    end

    // pack tokens in emit order
    always_comb begin
        o_tokens.count = 2'({1'b0, have_a} + {1'b0, have_b});
        o_tokens.tok0  = have_a ? tok_a : tok_b;
        o_tokens.tok1  = tok_b;
    end

endmodule

`default_nettype wire

// ===== rtl/script_token_scanner.sv =====
// script token scanner top level: input register, scan logic, token queue
// a byte goes from the input register through the scan logic into the token register
// throughput: one source byte per cycle while its tokens fit in the token queue; a byte that
//   makes two tokens holds the two-slot token register for two output transactions
// the scan itself is one pass of the per-byte mode update between registers
// reset: synchronous active-low; clears mode, position, start and all valids
`default_nettype none

module script_token_scanner
    import sts_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_source_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_token_offset,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);

    localparam int P = POSITION_BITS;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [2:0]          r_mode;
    logic [P-1:0]        r_pos;
    logic [P-1:0]        r_pstart;
    logic [1:0]          r_cnt;
    t_token              r_tok [2];
    logic                r_last [2];

    logic [1:0]          n_cnt;
    t_token              n_tok [2];
    logic                n_last [2];

    t_lex_tokens         lex_tokens;
    logic [2:0]          lex_mode;
    logic [P-1:0]        lex_pos;
    logic [P-1:0]        lex_pstart;

    logic                pop;
    logic [1:0]          remain;
    logic                advance;

    // per-byte scan
    sts_lexer #(
        .POSITION_BITS(P)
    ) u_lexer (
        .i_byte  (r_in_byte),
        .i_mode  (r_mode),
        .i_pos   (r_pos),
        .i_pstart(r_pstart),
        .o_tokens(lex_tokens),
        .o_mode  (lex_mode),
        .o_pos   (lex_pos),
        .o_pstart(lex_pstart)
    );

    // move a byte on when its tokens fit after this cycle's pop
    always_comb begin
        pop     = (r_cnt != 2'd0) && i_ready;
        remain  = r_cnt - {1'b0, pop};
        advance = r_in_valid &&
                  (({1'b0, remain} + {1'b0, lex_tokens.count}) <= 3'd2);
        o_ready = !r_in_valid || advance;
    end

    // token queue: shift on pop, append new tokens behind what remains
    // each slot keeps its own last-of-byte flag
    always_comb begin
        n_tok[0]  = pop ? r_tok[1] : r_tok[0];
        n_tok[1]  = r_tok[1];
        n_last[0] = pop ? r_last[1] : r_last[0];
        n_last[1] = r_last[1];
        n_cnt     = remain;
        if (advance) begin
            n_cnt = 2'(remain + lex_tokens.count);
            if (remain == 2'd0) begin
                n_tok[0]  = lex_tokens.tok0;
                n_tok[1]  = lex_tokens.tok1;
                n_last[0] = (lex_tokens.count != 2'd2);
                n_last[1] = 1'b1;
            end else if (remain == 2'd1) begin
                n_tok[1]  = lex_tokens.tok0;
                n_last[1] = 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_source_byte;
        end
    end

    // scanner state and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_cnt    <= 2'd0;
        end else begin
            if (advance) begin
                r_mode   <= lex_mode;
                r_pos    <= lex_pos;
                r_pstart <= lex_pstart;
            end
            r_cnt <= n_cnt;
        end
        r_tok[0]  <= n_tok[0];
        r_tok[1]  <= n_tok[1];
        r_last[0] <= n_last[0];
        r_last[1] <= n_last[1];
    end

    assign o_valid        = (r_cnt != 2'd0);
    assign o_token_kind   = r_tok[0].kind;
    assign o_token_offset = r_tok[0].offset;
    assign o_token_length = r_tok[0].length;
    assign o_last_of_run  = r_last[0];

    // checks on queue depth and state handling
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("token queue overfilled");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_byte == CH_NUL) |=> (r_mode == MODE_IDLE) && (r_pos == '0))
        else $error("end of script did not reset scanner state");

    a_end_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_byte == CH_NUL) && (remain == 2'd0)
        |=> o_valid && ((r_cnt == 2'd1) ? (o_token_kind == KIND_EOF)
                                        : (r_tok[1].kind == KIND_EOF)))
        else $error("end of script without eof token");

    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_byte != CH_NUL) |=> r_pos >= $past(r_pos))
        else $error("byte position went backward");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled source byte lost");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the script token scanner: token prediction and compare
`timescale 1ns / 1ps

module tb_top
    import sts_pkg::*;
();

    localparam int POS_BITS   = 16;
    localparam int POS_MAX    = (1 << POS_BITS) - 1;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RANDOM_CNT = 840;

    typedef struct {
        t_token tok;
        logic   last;
    } t_expected_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_source_byte;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_token_kind;
    logic [15:0] o_token_offset;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    // tokens predicted but not yet seen on the output
    t_expected_token expected_tokens[$];
    t_expected_token want;

    // predicted scanner state
    logic [2:0] lex_mode;
    int         lex_pos;
    int         lex_start;

    int  wrong_count;
    int  sent_count;
    int  stall_left;
    int  cycle_count;
    bit  quiet;

    script_token_scanner #(
        .POSITION_BITS(POS_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_source_byte  (i_source_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // character classes
    function automatic bit is_decimal(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    // single-byte punctuation, eof code when the byte is not one
    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        case (b)
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            ";": return KIND_SEMI;
            ",": return KIND_COMMA;
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "%": return KIND_PCT;
            "<": return KIND_LT;
            ">": return KIND_GT;
            default: return KIND_EOF;
        endcase
    endfunction

    function automatic logic [15:0] sat16(input int v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int sat_inc(input int v);
        return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function automatic t_token tok_of(input logic [4:0] k, input int off, input int len);
        t_token t;
        t.kind   = k;
        t.offset = sat16(off);
        t.length = sat16(len);
        return t;
    endfunction

    function automatic int run_len(input int p);
        return (p >= lex_start) ? p - lex_start : 0;
    endfunction

    // tokens caused by one source byte, appended in emit order
    task automatic predict_tokens(input logic [7:0] b);
        t_token          made[2];
        t_expected_token e;
        int              n;
        int              p;
        bit              taken;
        logic [4:0]      pk;
        n = 0;
        p = lex_pos;
        taken = 1'b0;

        // close or extend the pending token
        case (lex_mode)
            MODE_COMMENT: begin
                if (b == CH_LF) lex_mode = MODE_IDLE;
                taken = (b != CH_NUL);
            end
            MODE_STRING: begin
                if (b == CH_NUL || b == CH_QUOTE) begin
                    made[n] = tok_of(KIND_STRING, lex_start, run_len(p));
                    n++;
                end
                if (b == CH_QUOTE) lex_mode = MODE_IDLE;
                taken = (b != CH_NUL);
            end
            MODE_NUMBER: begin
                if (is_decimal(b)) begin
                    taken = 1'b1;
                end else begin
                    made[n] = tok_of(KIND_NUMBER, lex_start, run_len(p));
                    n++;
                    lex_mode = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                if (is_letter(b) || is_decimal(b)) begin
                    taken = 1'b1;
                end else begin
                    made[n] = tok_of(KIND_IDENT, lex_start, run_len(p));
                    n++;
                    lex_mode = MODE_IDLE;
                end
            end
            MODE_EQ: begin
                lex_mode = MODE_IDLE;
                if (b == CH_EQ) begin
                    made[n] = tok_of(KIND_EQEQ, lex_start, 2);
                    taken = 1'b1;
                end else begin
                    made[n] = tok_of(KIND_EQ, lex_start, 1);
                end
                n++;
            end
            default: lex_mode = MODE_IDLE;
        endcase

        // end of script flushes to eof and resets, otherwise scan the byte itself
        if (b == CH_NUL) begin
            made[n] = tok_of(KIND_EOF, p, 0);
            n++;
            lex_mode = MODE_IDLE;
            lex_pos = 0;
            lex_start = 0;
        end else begin
            if (!taken && !is_blank(b)) begin
                pk = punct_kind(b);
                if (b == CH_HASH) begin
                    lex_mode = MODE_COMMENT;
                end else if (pk != KIND_EOF) begin
                    made[n] = tok_of(pk, p, 1);
                    n++;
                end else if (b == CH_EQ) begin
                    lex_mode = MODE_EQ;
                    lex_start = p;
                end else if (b == CH_QUOTE) begin
                    lex_mode = MODE_STRING;
                    lex_start = sat_inc(p);
                end else if (is_decimal(b)) begin
                    lex_mode = MODE_NUMBER;
                    lex_start = p;
                end else if (is_letter(b)) begin
                    lex_mode = MODE_IDENT;
                    lex_start = p;
                end else begin
                    made[n] = tok_of(KIND_ERROR, p, 1);
                    n++;
                end
            end
            lex_pos = sat_inc(p);
        end

        for (int i = 0; i < n; i++) begin
            e.tok  = made[i];
            e.last = (i == n - 1);
            expected_tokens.push_back(e);
        end
    endtask

    // send one source byte and wait for its transaction
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 26) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_source_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sent_count++;
        predict_tokens(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // stop offering bytes until every predicted token has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // random content helpers
    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // any nonzero byte except the given terminator
    function automatic logic [7:0] rand_body(input logic [7:0] stop);
        logic [7:0] r;
        do r = 8'($urandom_range(1, 255)); while (r == stop);
        return r;
    endfunction

    // one lexically shaped fragment with random content
    task automatic send_random_token();
        string punct;
        int    len;
        punct = "{}();,+-*/%<>";
        case ($urandom_range(11))
            0, 1: begin
                len = $urandom_range(1, 8);
                send_byte(rand_alpha());
                for (int i = 1; i < len; i++)
                    send_byte($urandom_range(2) == 0 ? rand_digit() : rand_alpha());
            end
            2: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) send_byte(rand_digit());
            end
            3: begin
                len = $urandom_range(0, 10);
                send_byte(CH_QUOTE);
                for (int i = 0; i < len; i++) send_byte(rand_body(CH_QUOTE));
                if ($urandom_range(7) != 0) send_byte(CH_QUOTE);
            end
            4, 5: send_byte(punct[$urandom_range(punct.len() - 1)]);
            6: begin
                send_byte(CH_EQ);
                if ($urandom_range(1) == 0) send_byte(CH_EQ);
            end
            7, 11: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) send_byte(rand_blank());
            end
            8: begin
                len = $urandom_range(0, 8);
                send_byte(CH_HASH);
                for (int i = 0; i < len; i++) send_byte(rand_body(CH_LF));
                send_byte(CH_LF);
            end
            9: send_byte(8'($urandom_range(1, 255)));
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(59) == 0) send_byte(CH_NUL);
    endtask

    // every token kind, pending tokens closed by the next byte, error bytes
    task automatic test_every_token();
        send_text("x1=(2==\"s\"a;9@#c");
        send_byte(CH_LF);
        send_text("{}(),+-*/%<>");
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(CH_SPACE);
        send_byte(CH_NUL);
    endtask

    // end of script in string, equals, number, comment and idle modes, empty string, empty script
    task automatic test_end_cases();
        send_text("\"ab");
        send_byte(CH_NUL);
        send_text("=");
        send_byte(CH_NUL);
        send_text("7");
        send_byte(CH_NUL);
        send_text("#z");
        send_byte(CH_NUL);
        send_text("q\"\"");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
    endtask

    // random scripts, with a stretch where neither side idles
    task automatic test_random_scripts();
        int base;
        base = sent_count;
        while (sent_count < base + RANDOM_CNT) begin
            quiet = (sent_count >= base + 300) && (sent_count < base + 500);
            send_random_token();
        end
        quiet = 1'b0;
        send_byte(CH_NUL);
    endtask

    // output held off for a long while so the scanner fills and stalls its input
    task automatic test_backpressure();
        quiet = 1'b1;
        stall_left = 300;
        for (int i = 0; i < 80; i++) send_random_token();
        quiet = 1'b0;
        send_byte(CH_NUL);
    endtask

    // sender pauses mid script until the output has caught up
    task automatic test_drain_pause();
        send_text("abc=12");
        wait_drained();
        send_text(";\"xy");
        wait_drained();
        send_text("\" 5");
        send_byte(CH_NUL);
    endtask

    // receiver: random stalls, long hold-off on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 26);
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: wrong %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
            wrong_count++;
        end
    endtask

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                         $time, o_token_kind, o_token_offset);
                wrong_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", int'(want.tok.kind), int'(o_token_kind));
                check_field("token_offset", int'(want.tok.offset), int'(o_token_offset));
                check_field("token_length", int'(want.tok.length), int'(o_token_length));
                check_field("last_of_run", int'(want.last), int'(o_last_of_run));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("script_token_scanner: mismatch");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_source_byte    = 8'h00;
        i_ready          = 1'b0;
        quiet            = 1'b0;
        stall_left       = 0;
        wrong_count      = 0;
        sent_count       = 0;
        cycle_count      = 0;
        lex_mode         = MODE_IDLE;
        lex_pos          = 0;
        lex_start        = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_every_token();
        test_end_cases();
        test_random_scripts();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (wrong_count == 0 && expected_tokens.size() == 0) begin
            $display("script_token_scanner: match");
        end else begin
            $display("script_token_scanner: mismatch");
        end
        $finish;
    end

endmodule

// ===== script_token_scanner.f =====
rtl/sts_pkg.sv
rtl/sts_lexer.sv
rtl/script_token_scanner.sv
tb/tb_top.sv
